@@ rtl/jlt_pkg.sv @@
// Shared types and constants for the Jack tokenizer core.
// Holds the result and run formats, token type codes and the keyword table.
// No dependencies.
package jlt_pkg;

    localparam int NUM_KW  = 21;
    localparam int RUN_MAX = 4;

    // token type codes
    localparam logic [2:0] TT_KEYWORD = 3'd0;
    localparam logic [2:0] TT_SYMBOL  = 3'd1;
    localparam logic [2:0] TT_IDENT   = 3'd2;
    localparam logic [2:0] TT_INT     = 3'd3;
    localparam logic [2:0] TT_STRING  = 3'd4;
    localparam logic [2:0] TT_INVALID = 3'd5;

    localparam logic [14:0] INT_SAT      = 15'd32767;
    localparam logic [20:0] KW_ALL_ALIVE = 21'h1FFFFF;

    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    // keyword text, right-justified, and its length
    localparam logic [87:0] KW_STR [NUM_KW] = '{
        "class", "method", "function", "constructor", "int", "boolean", "char",
        "void", "var", "static", "field", "let", "do", "if", "else", "while",
        "return", "true", "false", "null", "this"};

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd6, 4'd8, 4'd11, 4'd3, 4'd7, 4'd4,
        4'd4, 4'd3, 4'd6, 4'd5, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5,
        4'd6, 4'd4, 4'd5, 4'd4, 4'd4};

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_value;
        logic [2:0]  token_type;
        logic [4:0]  keyword_code;
        logic [14:0] int_value;
    } t_result;

    // all results caused by one accepted byte
    typedef struct packed {
        logic [2:0]                count;
        t_result [RUN_MAX-1:0]     item;
    } t_run;

    // character at position idx of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] idx);
        logic [87:0] s;
        logic [3:0]  sh;
        logic [7:0]  c;
        s = KW_STR[k];
        c = 8'h00;
        if (idx < KW_LEN[k]) begin
            sh = KW_LEN[k] - 4'd1 - idx;
            c  = s[{sh, 3'b000} +: 8];
        end
        return c;
    endfunction

endpackage

@@ rtl/jlt_front.sv @@
// Scanner front end: holds the scan state and classifies each accepted byte.
// Builds the run of up to four results that the byte causes.
// Depends on jlt_pkg.
module jlt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte_value,
    input  logic          i_end_of_text,
    output logic          o_push,
    output jlt_pkg::t_run o_run
);
    import jlt_pkg::*;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_SLASH  = 3'd1;
    localparam logic [2:0] M_LINE   = 3'd2;
    localparam logic [2:0] M_BLOCK  = 3'd3;
    localparam logic [2:0] M_STAR   = 3'd4;
    localparam logic [2:0] M_STRING = 3'd5;
    localparam logic [2:0] M_INT    = 3'd6;
    localparam logic [2:0] M_WORD   = 3'd7;

    logic [2:0]  r_mode,  n_mode;
    logic [20:0] r_alive, n_alive;
    logic [3:0]  r_widx,  n_widx;
    logic [14:0] r_acc,   n_acc;

    logic [2:0]  s_mode;
    logic [20:0] s_alive;
    logic [3:0]  s_widx;
    logic [14:0] s_acc;
    t_result     st0, st1, pre0, pre1;
    logic [1:0]  st_cnt, pre_cnt, eff_cnt;
    logic        do_start;
    t_run        run;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_sym(input logic [7:0] b);
        return b inside {"{", "}", "(", ")", "[", "]", ".", ",", ";", "+", "-",
                         "*", "/", "&", "|", "<", ">", "=", "~"};
    endfunction

    function automatic logic [20:0] word_take(input logic [20:0] alive,
                                              input logic [3:0] idx,
                                              input logic [7:0] b);
        logic [20:0] nxt;
        for (int k = 0; k < NUM_KW; k++) begin
            nxt[k] = alive[k] && (idx < KW_LEN[k]) && (kw_char(k, idx) == b);
        end
        return nxt;
    endfunction

    function automatic logic [14:0] int_take(input logic [14:0] acc,
                                             input logic [7:0] b);
        logic [19:0] v;
        v = ({5'd0, acc} << 3) + ({5'd0, acc} << 1) + {16'd0, b[3:0]};
        return (v > {5'd0, INT_SAT}) ? INT_SAT : v[14:0];
    endfunction

    function automatic t_result mk_text(input logic [7:0] b);
        t_result r;
        r = '0;
        r.char_value = b;
        return r;
    endfunction

    function automatic t_result mk_end(input logic [2:0] tt, input logic [4:0] kw,
                                       input logic [14:0] iv);
        t_result r;
        r = '0;
        r.kind         = 1'b1;
        r.token_type   = tt;
        r.keyword_code = kw;
        r.int_value    = iv;
        return r;
    endfunction

    function automatic t_result word_end(input logic [20:0] alive, input logic [3:0] widx);
        t_result r;
        r = mk_end(TT_IDENT, 5'd0, 15'd0);
        // scan downwards so the lowest matching keyword wins
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (alive[k] && KW_LEN[k] == widx) begin
                r = mk_end(TT_KEYWORD, 5'(k), 15'd0);
            end
        end
        return r;
    endfunction

    // classification of a byte seen from idle
    always_comb begin
        s_mode  = M_IDLE;
        s_alive = KW_ALL_ALIVE;
        s_widx  = 4'd0;
        s_acc   = 15'd0;
        st0     = mk_text(i_byte_value);
        st1     = mk_end(TT_INVALID, 5'd0, 15'd0);
        st_cnt  = 2'd0;
        if (is_space(i_byte_value)) begin
            st_cnt = 2'd0;
        end else if (i_byte_value == CH_SLASH) begin
            s_mode = M_SLASH;
        end else if (is_sym(i_byte_value)) begin
            st1    = mk_end(TT_SYMBOL, 5'd0, 15'd0);
            st_cnt = 2'd2;
        end else if (i_byte_value == CH_QUOTE) begin
            s_mode = M_STRING;
        end else if (is_digit(i_byte_value)) begin
            s_mode = M_INT;
            s_acc  = int_take(15'd0, i_byte_value);
            st_cnt = 2'd1;
        end else if (is_alpha(i_byte_value) || i_byte_value == CH_UNDERSCORE) begin
            s_mode  = M_WORD;
            s_alive = word_take(KW_ALL_ALIVE, 4'd0, i_byte_value);
            s_widx  = 4'd1;
            st_cnt  = 2'd1;
        end else begin
            st_cnt = 2'd2;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_alive  = r_alive;
        n_widx   = r_widx;
        n_acc    = r_acc;
        pre0     = mk_text(CH_SLASH);
        pre1     = mk_end(TT_SYMBOL, 5'd0, 15'd0);
        pre_cnt  = 2'd0;
        do_start = 1'b0;
        if (i_end_of_text) begin
            case (r_mode)
                M_WORD: begin
                    pre0    = word_end(r_alive, r_widx);
                    pre_cnt = 2'd1;
                end
                M_INT: begin
                    pre0    = mk_end(TT_INT, 5'd0, r_acc);
                    pre_cnt = 2'd1;
                end
                M_STRING: begin
                    pre0    = mk_end(TT_STRING, 5'd0, 15'd0);
                    pre_cnt = 2'd1;
                end
                M_SLASH: begin
                    pre_cnt = 2'd2;
                end
                default: begin
                    pre_cnt = 2'd0;
                end
            endcase
            n_mode  = M_IDLE;
            n_alive = KW_ALL_ALIVE;
            n_widx  = 4'd0;
            n_acc   = 15'd0;
        end else begin
            case (r_mode)
                M_IDLE: begin
                    do_start = 1'b1;
                end
                M_SLASH: begin
                    if (i_byte_value == CH_SLASH) begin
                        n_mode = M_LINE;
                    end else if (i_byte_value == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else begin
                        // emit the held slash as a symbol, then rescan
                        pre_cnt  = 2'd2;
                        do_start = 1'b1;
                    end
                end
                M_LINE: begin
                    if (i_byte_value == CH_NEWLINE) begin
                        n_mode = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (i_byte_value == CH_STAR) begin
                        n_mode = M_STAR;
                    end
                end
                M_STAR: begin
                    if (i_byte_value == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (i_byte_value != CH_STAR) begin
                        n_mode = M_BLOCK;
                    end
                end
                M_STRING: begin
                    pre_cnt = 2'd1;
                    if (i_byte_value == CH_QUOTE) begin
                        pre0    = mk_end(TT_STRING, 5'd0, 15'd0);
                        n_mode  = M_IDLE;
                        n_alive = KW_ALL_ALIVE;
                        n_widx  = 4'd0;
                        n_acc   = 15'd0;
                    end else begin
                        pre0 = mk_text(i_byte_value);
                    end
                end
                M_INT: begin
                    pre_cnt = 2'd1;
                    if (is_digit(i_byte_value)) begin
                        n_acc = int_take(r_acc, i_byte_value);
                        pre0  = mk_text(i_byte_value);
                    end else begin
                        pre0     = mk_end(TT_INT, 5'd0, r_acc);
                        do_start = 1'b1;
                    end
                end
                default: begin
                    pre_cnt = 2'd1;
                    if (is_alpha(i_byte_value) || is_digit(i_byte_value) ||
                        i_byte_value == CH_UNDERSCORE) begin
                        n_alive = word_take(r_alive, r_widx, i_byte_value);
                        n_widx  = (r_widx == 4'd15) ? r_widx : r_widx + 4'd1;
                        pre0    = mk_text(i_byte_value);
                    end else begin
                        pre0     = word_end(r_alive, r_widx);
                        do_start = 1'b1;
                    end
                end
            endcase
        end
        if (do_start) begin
            n_mode  = s_mode;
            n_alive = s_alive;
            n_widx  = s_widx;
            n_acc   = s_acc;
        end
    end

    // pack the closing results ahead of the new token's results
    always_comb begin
        eff_cnt   = do_start ? st_cnt : 2'd0;
        run.count = {1'b0, pre_cnt} + {1'b0, eff_cnt};
        case (pre_cnt)
            2'd0: begin
                run.item[0] = st0;
                run.item[1] = st1;
                run.item[2] = st0;
            end
            2'd1: begin
                run.item[0] = pre0;
                run.item[1] = st0;
                run.item[2] = st1;
            end
            default: begin
                run.item[0] = pre0;
                run.item[1] = pre1;
                run.item[2] = st0;
            end
        endcase
        run.item[3] = st1;
    end

    assign o_push = i_accept && (run.count != 3'd0);
    assign o_run  = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_alive <= KW_ALL_ALIVE;
            r_widx  <= 4'd0;
            r_acc   <= 15'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_alive <= n_alive;
            r_widx  <= n_widx;
            r_acc   <= n_acc;
        end
    end

endmodule

@@ rtl/jlt_run_fifo.sv @@
// Short queue of result runs between the scanner and the output sequencer.
// Depends on jlt_pkg.
module jlt_run_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jlt_pkg::t_run i_data,
    input  logic          i_pop,
    output jlt_pkg::t_run o_data,
    output logic          o_empty,
    output logic          o_full
);
    import jlt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ rtl/jlt_back.sv @@
// Output sequencer: presents queued runs one result a cycle unless stalled.
// Marks the last result of each run. Depends on jlt_pkg.
module jlt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jlt_pkg::t_run    i_fifo_data,
    input  logic             i_fifo_empty,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output jlt_pkg::t_result o_result,
    output logic             o_last
);
    import jlt_pkg::*;

    localparam int IW = $clog2(RUN_MAX);

    logic          r_busy;
    t_run          r_run;
    logic [IW-1:0] r_idx;
    logic          sent, last;

    assign sent  = r_busy && !i_out_stall;
    assign last  = ({{(3-IW){1'b0}}, r_idx} == (r_run.count - 3'd1));
    assign o_pop = !i_fifo_empty && (!r_busy || (sent && last));

    assign o_out_valid = r_busy;
    assign o_result    = r_run.item[r_idx];
    assign o_last      = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_fifo_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (sent) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

endmodule

@@ rtl/jack_language_tokenizer_core.sv @@
// Top level of the Jack tokenizer: scanner front end, run queue, output sequencer.
// Depends on jlt_pkg, jlt_front, jlt_run_fifo and jlt_back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  input   | in        | i_in_valid / o_in_stall   | byte_value, end_of_text
//  output  | out       | o_out_valid / i_out_stall | kind, char_value, token_type,
//          |           |                           | keyword_code, int_value, last_of_run
//
// One byte is taken per cycle while the run queue has room; each byte yields 0 to 4 results.
// Results leave one per cycle unless stalled, via the queue memory then the run register.
// Sustained rate is one byte per cycle while runs average one result or less; the output
// port's single result per cycle sets the limit, and o_in_stall rises when the queue fills.
// Reset is synchronous and clears the scan state, the queue and the output register.
module jack_language_tokenizer_core #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_char_value,
    output logic [2:0]  o_token_type,
    output logic [4:0]  o_keyword_code,
    output logic [14:0] o_int_value,
    output logic        o_last_of_run
);
    import jlt_pkg::*;

    logic    accept, push, pop, q_empty, q_full;
    t_run    push_run, head_run;
    t_result result;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    jlt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte_value  (i_byte_value),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_run         (push_run)
    );

    jlt_run_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_run),
        .i_pop   (pop),
        .o_data  (head_run),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    jlt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_data  (head_run),
        .i_fifo_empty (q_empty),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (result),
        .o_last       (o_last_of_run)
    );

    assign o_kind         = result.kind;
    assign o_char_value   = result.char_value;
    assign o_token_type   = result.token_type;
    assign o_keyword_code = result.keyword_code;
    assign o_int_value    = result.int_value;

endmodule

@@ rtl/jlt_checker.sv @@
// Port-level checks for the Jack tokenizer core, bound to the top level.
// Depends on jlt_pkg and jack_language_tokenizer_core.
module jlt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_byte_value,
    input logic        i_end_of_text,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_kind,
    input logic [7:0]  o_char_value,
    input logic [2:0]  o_token_type,
    input logic [4:0]  o_keyword_code,
    input logic [14:0] o_int_value,
    input logic        o_last_of_run
);
    import jlt_pkg::*;

    // a stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid &&
        $stable({i_byte_value, i_end_of_text}))
        else $error("request changed while stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
        $stable({o_kind, o_char_value, o_token_type, o_keyword_code, o_int_value,
                 o_last_of_run}))
        else $error("result changed while stalled");

    // reset empties the queue and the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

    a_text_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |->
        o_token_type == TT_KEYWORD && o_keyword_code == 5'd0 && o_int_value == 15'd0)
        else $error("text byte carries token fields");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_char_value == 8'd0 &&
        (o_token_type == TT_KEYWORD || o_keyword_code == 5'd0) &&
        (o_token_type == TT_INT || o_int_value == 15'd0))
        else $error("token end fields inconsistent with type");

endmodule

bind jack_language_tokenizer_core jlt_checker u_jlt_checker (.*);

@@ test/jack_language_tokenizer_core_tb.sv @@
// Testbench for jack_language_tokenizer_core: directed table then random Jack source text.
// Results are checked against the directed table or a cycle-free token predictor here.
// Depends on jlt_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module jack_language_tokenizer_core_tb;
    import jlt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_GOAL   = 250;
    localparam logic [4:0] KW_CLASS = 5'd0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SLASH, ST_LINE, ST_BLOCK, ST_STAR, ST_STRING, ST_INT, ST_WORD
    } t_scan_state;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_tok_out;

    typedef struct packed {
        logic [7:0]  b;
        logic        eot;
        logic        typed;
        logic        echo;
        logic [2:0]  tt;
        logic [4:0]  kw;
        logic [14:0] iv;
    } t_dir_row;

    localparam string SYM_SET    = "{}()[].,;+-*/&|<>=~";
    localparam string BLOCK_FILL = "**/ a\n";

    string kw_names [NUM_KW] = '{
        "class", "method", "function", "constructor", "int", "boolean", "char",
        "void", "var", "static", "field", "let", "do", "if", "else", "while",
        "return", "true", "false", "null", "this"};

    // echo flag set: text byte then token end; otherwise token end alone
    t_dir_row dir_rows [26] = '{
        '{8'h7B,      1'b0, 1'b1, 1'b1, TT_SYMBOL,  5'd0,     15'd0},
        '{8'h00,      1'b0, 1'b1, 1'b1, TT_INVALID, 5'd0,     15'd0},
        '{8'hFF,      1'b0, 1'b1, 1'b1, TT_INVALID, 5'd0,     15'd0},
        '{CH_QUOTE,   1'b0, 1'b0, 1'b0, TT_STRING,  5'd0,     15'd0},
        '{CH_NEWLINE, 1'b0, 1'b0, 1'b0, TT_STRING,  5'd0,     15'd0},
        '{8'h00,      1'b1, 1'b1, 1'b0, TT_STRING,  5'd0,     15'd0},
        '{"c",        1'b0, 1'b0, 1'b0, TT_IDENT,   5'd0,     15'd0},
        '{"l",        1'b0, 1'b0, 1'b0, TT_IDENT,   5'd0,     15'd0},
        '{"a",        1'b0, 1'b0, 1'b0, TT_IDENT,   5'd0,     15'd0},
        '{"s",        1'b0, 1'b0, 1'b0, TT_IDENT,   5'd0,     15'd0},
        '{"s",        1'b0, 1'b0, 1'b0, TT_IDENT,   5'd0,     15'd0},
        '{CH_SLASH,   1'b0, 1'b1, 1'b0, TT_KEYWORD, KW_CLASS, 15'd0},
        '{CH_STAR,    1'b0, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0},
        '{CH_STAR,    1'b0, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0},
        '{CH_SLASH,   1'b0, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0},
        '{CH_SLASH,   1'b0, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0},
        '{CH_SLASH,   1'b1, 1'b1, 1'b1, TT_SYMBOL,  5'd0,     15'd0},
        '{"9",        1'b0, 1'b0, 1'b0, TT_INT,     5'd0,     15'd0},
        '{"9",        1'b0, 1'b0, 1'b0, TT_INT,     5'd0,     15'd0},
        '{"9",        1'b0, 1'b0, 1'b0, TT_INT,     5'd0,     15'd0},
        '{"9",        1'b0, 1'b0, 1'b0, TT_INT,     5'd0,     15'd0},
        '{"9",        1'b0, 1'b0, 1'b0, TT_INT,     5'd0,     15'd0},
        '{8'h00,      1'b1, 1'b1, 1'b0, TT_INT,     5'd0,     INT_SAT},
        '{CH_SLASH,   1'b0, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0},
        '{CH_SLASH,   1'b0, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0},
        '{8'h00,      1'b1, 1'b0, 1'b0, TT_SYMBOL,  5'd0,     15'd0}};

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_byte_value   = 8'h00;
    logic        i_end_of_text  = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_char_value;
    logic [2:0]  o_token_type;
    logic [4:0]  o_keyword_code;
    logic [14:0] o_int_value;
    logic        o_last_of_run;

    // predictor state
    t_scan_state sc_mode;
    logic [20:0] kw_live;
    logic [3:0]  word_len;
    logic [14:0] int_acc;
    t_result     run_res [RUN_MAX];
    int          run_len;

    t_tok_out    exp_q [$];
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          taken_items   = 0;
    int          in_idle_pct   = 22;
    int          out_stall_pct = 75;

    jack_language_tokenizer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_value   (i_byte_value),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_char_value   (o_char_value),
        .o_token_type   (o_token_type),
        .o_keyword_code (o_keyword_code),
        .o_int_value    (o_int_value),
        .o_last_of_run  (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic bit is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_symbol(input logic [7:0] c);
        for (int i = 0; i < SYM_SET.len(); i++)
            if (SYM_SET[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    // add one expected result at the tail of the queue
    task automatic append_expected(input t_tok_out e);
        exp_q.insert(exp_q.size(), e);
    endtask

    task automatic emit(input logic k, input logic [7:0] ch, input logic [2:0] tt,
                        input logic [4:0] kw, input logic [14:0] iv);
        if (run_len < RUN_MAX) begin
            run_res[run_len].kind         = k;
            run_res[run_len].char_value   = ch;
            run_res[run_len].token_type   = tt;
            run_res[run_len].keyword_code = kw;
            run_res[run_len].int_value    = iv;
            run_len++;
        end
    endtask

    task automatic clear_scan();
        sc_mode  = ST_IDLE;
        kw_live  = KW_ALL_ALIVE;
        word_len = 4'd0;
        int_acc  = 15'd0;
    endtask

    task automatic word_consume(input logic [7:0] c);
        for (int k = 0; k < NUM_KW; k++) begin
            if (kw_live[k] && (word_len >= kw_names[k].len() || kw_names[k][word_len] != c))
                kw_live[k] = 1'b0;
        end
        if (word_len < 4'd15) word_len++;
    endtask

    task automatic word_close();
        bit found;
        found = 1'b0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!found && kw_live[k] && kw_names[k].len() == word_len) begin
                emit(1'b1, 8'h00, TT_KEYWORD, 5'(k), 15'd0);
                found = 1'b1;
            end
        end
        if (!found) emit(1'b1, 8'h00, TT_IDENT, 5'd0, 15'd0);
        clear_scan();
    endtask

    task automatic int_consume(input logic [7:0] c);
        logic [31:0] v;
        v = 32'(int_acc) * 32'd10 + 32'(c - 8'h30);
        int_acc = (v > 32'(INT_SAT)) ? INT_SAT : v[14:0];
    endtask

    task automatic open_token(input logic [7:0] c);
        clear_scan();
        if (is_space(c)) begin
        end else if (c == CH_SLASH) begin
            sc_mode = ST_SLASH;
        end else if (is_symbol(c)) begin
            emit(1'b0, c, 3'd0, 5'd0, 15'd0);
            emit(1'b1, 8'h00, TT_SYMBOL, 5'd0, 15'd0);
        end else if (c == CH_QUOTE) begin
            sc_mode = ST_STRING;
        end else if (is_digit(c)) begin
            sc_mode = ST_INT;
            int_consume(c);
            emit(1'b0, c, 3'd0, 5'd0, 15'd0);
        end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
            sc_mode = ST_WORD;
            word_consume(c);
            emit(1'b0, c, 3'd0, 5'd0, 15'd0);
        end else begin
            emit(1'b0, c, 3'd0, 5'd0, 15'd0);
            emit(1'b1, 8'h00, TT_INVALID, 5'd0, 15'd0);
        end
    endtask

    // work out the result run caused by one accepted request
    task automatic tokenize(input logic [7:0] c, input logic eot);
        run_len = 0;
        if (eot) begin
            case (sc_mode)
                ST_WORD:   word_close();
                ST_INT:    emit(1'b1, 8'h00, TT_INT, 5'd0, int_acc);
                ST_STRING: emit(1'b1, 8'h00, TT_STRING, 5'd0, 15'd0);
                ST_SLASH: begin
                    emit(1'b0, CH_SLASH, 3'd0, 5'd0, 15'd0);
                    emit(1'b1, 8'h00, TT_SYMBOL, 5'd0, 15'd0);
                end
                default: ;
            endcase
            clear_scan();
        end else begin
            case (sc_mode)
                ST_IDLE: open_token(c);
                ST_SLASH: begin
                    if (c == CH_SLASH) sc_mode = ST_LINE;
                    else if (c == CH_STAR) sc_mode = ST_BLOCK;
                    else begin
                        emit(1'b0, CH_SLASH, 3'd0, 5'd0, 15'd0);
                        emit(1'b1, 8'h00, TT_SYMBOL, 5'd0, 15'd0);
                        open_token(c);
                    end
                end
                ST_LINE:  if (c == CH_NEWLINE) sc_mode = ST_IDLE;
                ST_BLOCK: if (c == CH_STAR) sc_mode = ST_STAR;
                ST_STAR: begin
                    if (c == CH_SLASH) sc_mode = ST_IDLE;
                    else if (c != CH_STAR) sc_mode = ST_BLOCK;
                end
                ST_STRING: begin
                    if (c == CH_QUOTE) begin
                        emit(1'b1, 8'h00, TT_STRING, 5'd0, 15'd0);
                        clear_scan();
                    end else begin
                        emit(1'b0, c, 3'd0, 5'd0, 15'd0);
                    end
                end
                ST_INT: begin
                    if (is_digit(c)) begin
                        int_consume(c);
                        emit(1'b0, c, 3'd0, 5'd0, 15'd0);
                    end else begin
                        emit(1'b1, 8'h00, TT_INT, 5'd0, int_acc);
                        open_token(c);
                    end
                end
                default: begin
                    if (is_word(c)) begin
                        word_consume(c);
                        emit(1'b0, c, 3'd0, 5'd0, 15'd0);
                    end else begin
                        word_close();
                        open_token(c);
                    end
                end
            endcase
        end
    endtask

    task automatic queue_predicted();
        t_tok_out e;
        for (int i = 0; i < run_len; i++) begin
            e.res  = run_res[i];
            e.last = (i == run_len - 1);
            append_expected(e);
        end
    endtask

    // present one request, hold it until taken, then predict its results
    task automatic send_byte(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_byte_value  <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_in_stall);
        tokenize(c, eot);
    endtask

    task automatic feed(input logic [7:0] c, input logic eot);
        send_byte(c, eot);
        queue_predicted();
        taken_items++;
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (exp_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_word_char();
        int p;
        p = $urandom_range(62);
        if (p < 26) return 8'("a" + p);
        if (p < 52) return 8'("A" + p - 26);
        if (p < 62) return 8'("0" + p - 52);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] rand_space();
        logic [7:0] c;
        c = 8'($urandom_range(8, 13));
        return (c == 8'd8) ? 8'd32 : c;
    endfunction

    // one random token, mostly well formed, sometimes noise
    task automatic feed_token();
        int          pick;
        int          k;
        int          n;
        logic [7:0]  c;
        pick = $urandom_range(99);
        if (pick < 18) begin
            k = $urandom_range(NUM_KW - 1);
            for (int i = 0; i < kw_names[k].len(); i++) feed(kw_names[k][i], 1'b0);
        end else if (pick < 33) begin
            if ($urandom_range(99) < 30) begin
                // keyword prefix with a tail, at times the whole keyword
                k = $urandom_range(NUM_KW - 1);
                n = $urandom_range(1, kw_names[k].len());
                for (int i = 0; i < n; i++) feed(kw_names[k][i], 1'b0);
                n = $urandom_range(0, 3);
            end else begin
                c = rand_word_char();
                if (is_digit(c)) c = CH_UNDERSCORE;
                feed(c, 1'b0);
                n = ($urandom_range(99) < 10) ? $urandom_range(11, 19) : $urandom_range(0, 7);
            end
            for (int i = 0; i < n; i++) feed(rand_word_char(), 1'b0);
        end else if (pick < 46) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) feed(8'("0" + $urandom_range(9)), 1'b0);
        end else if (pick < 56) begin
            feed(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                c = ($urandom_range(99) < 8) ? CH_NEWLINE : 8'($urandom_range(32, 126));
                if (c == CH_QUOTE) c = "q";
                feed(c, 1'b0);
            end
            if ($urandom_range(99) < 15) feed(8'($urandom_range(255)), 1'b1);
            else feed(CH_QUOTE, 1'b0);
        end else if (pick < 71) begin
            feed(SYM_SET[$urandom_range(SYM_SET.len() - 1)], 1'b0);
        end else if (pick < 77) begin
            feed(CH_SLASH, 1'b0);
            feed(CH_SLASH, 1'b0);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(255));
                if (c == CH_NEWLINE) c = "n";
                feed(c, 1'b0);
            end
            feed(CH_NEWLINE, 1'b0);
        end else if (pick < 83) begin
            feed(CH_SLASH, 1'b0);
            feed(CH_STAR, 1'b0);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) feed(BLOCK_FILL[$urandom_range(BLOCK_FILL.len() - 1)], 1'b0);
            feed(CH_STAR, 1'b0);
            feed(CH_SLASH, 1'b0);
        end else if (pick < 88) begin
            feed(rand_space(), 1'b0);
        end else if (pick < 94) begin
            feed(8'($urandom_range(255)), 1'b0);
        end else if (pick < 97) begin
            feed(8'($urandom_range(255)), 1'b1);
        end else begin
            c = ($urandom_range(1) == 0) ? 8'($urandom_range(128, 255)) : "#";
            feed(c, 1'b0);
        end
        if ($urandom_range(99) < 60) feed(rand_space(), 1'b0);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tok_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_q.size() == 0) begin
                $error("result with nothing expected: kind %0d char %0d type %0d",
                       o_kind, o_char_value, o_token_type);
                fail_count++;
            end else begin
                want = exp_q.pop_front();
                check_field("kind", int'(want.res.kind), int'(o_kind));
                check_field("char_value", int'(want.res.char_value), int'(o_char_value));
                check_field("token_type", int'(want.res.token_type), int'(o_token_type));
                check_field("keyword_code", int'(want.res.keyword_code),
                            int'(o_keyword_code));
                check_field("int_value", int'(want.res.int_value), int'(o_int_value));
                check_field("last_of_run", int'(want.last), int'(o_last_of_run));
            end
        end
    end

    initial begin : stimulus
        t_tok_out e;
        int       phase_no;
        phase_no = 0;
        clear_scan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].b, dir_rows[i].eot);
            if (dir_rows[i].typed) begin
                if (dir_rows[i].echo) begin
                    e = '0;
                    e.res.char_value = dir_rows[i].b;
                    append_expected(e);
                end
                e = '0;
                e.res.kind         = 1'b1;
                e.res.token_type   = dir_rows[i].tt;
                e.res.keyword_code = dir_rows[i].kw;
                e.res.int_value    = dir_rows[i].iv;
                e.last             = 1'b1;
                append_expected(e);
            end else begin
                queue_predicted();
            end
        end

        while (taken_items < ITEM_GOAL) begin
            feed_token();
            // hold the sender until the block drains, then change idle and stall rates
            if (phase_no == 0 && taken_items >= ITEM_GOAL / 3) begin
                hold_until_drained();
                in_idle_pct   = 75;
                out_stall_pct = 22;
                phase_no      = 1;
            end else if (phase_no == 1 && taken_items >= 2 * ITEM_GOAL / 3) begin
                hold_until_drained();
                in_idle_pct   = 0;
                out_stall_pct = 0;
                phase_no      = 2;
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (exp_q.size() != 0) begin
            $error("%0d expected results never arrived", exp_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
